### design/pcsg_pkg.sv
package pcsg_pkg;
	localparam int CORDIC_ITERATIONS = 16;
	localparam int COORD_BITS = 14;
	localparam int ITER_BITS = $clog2(CORDIC_ITERATIONS + 1);
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [35:0] PI_Q29 = 36'd1686629713;

	localparam logic [1:0] REG_SHAPE = 2'd0;
	localparam logic [1:0] REG_CENTER_X = 2'd1;
	localparam logic [1:0] REG_CENTER_Y = 2'd2;

	localparam logic [3:0] SH_NONE = 4'd0;
	localparam logic [3:0] SH_ASTROID = 4'd1;
	localparam logic [3:0] SH_CYCLOID = 4'd2;
	localparam logic [3:0] SH_HUYGENS = 4'd3;
	localparam logic [3:0] SH_HYPO = 4'd4;
	localparam logic [3:0] SH_LINE = 4'd5;
	localparam logic [3:0] SH_CIRCLE = 4'd6;
	localparam logic [3:0] SH_ELLIPSE = 4'd7;
	localparam logic [3:0] SH_EPI = 4'd8;
	localparam logic [3:0] SH_STAR = 4'd9;
	localparam logic [3:0] SH_CLOUD = 4'd10;
	localparam logic [3:0] SH_ICLOUD = 4'd11;

	typedef struct packed {
		logic start;
		logic [3:0] shape;
		logic [9:0] index;
	} pcsg_cmd_t;

	typedef struct packed {
		logic done;
	} pcsg_stat_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] k);
		logic [31:0] r;
		unique case (k)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic [9:0] shape_steps(input logic [3:0] sh);
		logic [9:0] r;
		unique case (sh)
			SH_ASTROID: r = 10'd250;
			SH_CYCLOID: r = 10'd128;
			SH_HUYGENS: r = 10'd256;
			SH_HYPO: r = 10'd256;
			SH_LINE: r = 10'd128;
			SH_CIRCLE: r = 10'd120;
			SH_ELLIPSE: r = 10'd256;
			SH_EPI: r = 10'd512;
			SH_STAR: r = 10'd256;
			SH_CLOUD: r = 10'd128;
			SH_ICLOUD: r = 10'd128;
			default: r = 10'd0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] shape_turns(input logic [3:0] sh);
		logic [3:0] r;
		unique case (sh)
			SH_CYCLOID: r = 4'd2;
			SH_HUYGENS: r = 4'd2;
			SH_LINE: r = 4'd0;
			SH_EPI: r = 4'd6;
			SH_STAR: r = 4'd3;
			SH_CLOUD: r = 4'd14;
			SH_ICLOUD: r = 4'd14;
			default: r = 4'd1;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] shape_scale(input logic [3:0] sh);
		logic [6:0] r;
		unique case (sh)
			SH_ASTROID: r = 7'd90;
			SH_HYPO: r = 7'd40;
			SH_LINE: r = 7'd100;
			SH_CIRCLE: r = 7'd100;
			SH_ELLIPSE: r = 7'd75;
			SH_STAR: r = 7'd25;
			default: r = 7'd10;
		endcase
		return r;
	endfunction
endpackage

### design/pcsg_div.sv
module pcsg_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] num,
	input logic [15:0] den,
	output logic busy,
	output logic [47:0] quo
);
	logic [5:0] cnt_q;
	logic [63:0] n_q;
	logic [16:0] rem_q;
	logic [15:0] den_q;
	logic [16:0] sh;
	logic [16:0] df;

	always_comb begin
		sh = {rem_q[15:0], n_q[63]};
		df = sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd48;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= {num[47:0], 16'd0};
			rem_q <= {1'b0, num[63:48]};
			den_q <= den;
			quo <= '0;
		end else if (cnt_q != 6'd0) begin
			n_q <= {n_q[62:0], 1'b0};
			if (!df[16]) begin
				rem_q <= df;
				quo <= {quo[46:0], 1'b1};
			end else begin
				rem_q <= sh;
				quo <= {quo[46:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != 6'd0);
endmodule

### design/pcsg_datapath.sv
module pcsg_datapath (
	input logic clk,
	input logic arst_n,
	input pcsg_pkg::pcsg_cmd_t cmd,
	input logic [11:0] center_x,
	input logic [11:0] center_y,
	output pcsg_pkg::pcsg_stat_t stat,
	output logic signed [pcsg_pkg::COORD_BITS-1:0] px,
	output logic signed [pcsg_pkg::COORD_BITS-1:0] py
);
	localparam int CB = pcsg_pkg::COORD_BITS;
	localparam int ITB = pcsg_pkg::ITER_BITS;
	localparam logic [4:0] P_IDLE = 5'd0, P_PH1 = 5'd1, P_PH1W = 5'd2, P_C1 = 5'd3,
		P_C1W = 5'd4, P_PH2 = 5'd5, P_PH2W = 5'd6, P_C2 = 5'd7, P_C2W = 5'd8,
		P_T = 5'd9, P_TW = 5'd10, P_M1 = 5'd11, P_M2 = 5'd12, P_M3 = 5'd13,
		P_M4 = 5'd14, P_COMB = 5'd15, P_PIXX = 5'd16, P_PIXY = 5'd17, P_DONE = 5'd18;

	logic [4:0] ph_q;
	logic [3:0] sh_q;
	logic [9:0] i_q;
	logic div_start;
	logic [63:0] div_num;
	logic [15:0] div_den;
	logic div_busy;
	logic [47:0] div_quo;
	logic [ITB-1:0] k_q;
	logic signed [33:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic neg_q;
	logic signed [19:0] c1_q, s1_q, c2_q, s2_q;
	logic signed [23:0] t_q;
	logic signed [40:0] ax_q, ay_q;
	logic [4:0] kn, kd;
	logic [15:0] dprod;
	logic [31:0] phase;
	logic signed [19:0] rc, rs;
	logic signed [39:0] mp1, mp2;
	logic signed [19:0] mr1, mr2;
	logic signed [40:0] vx, vy;
	logic signed [63:0] pacc;
	logic signed [63:0] pabs;
	logic signed [63:0] ptr;
	logic signed [CB-1:0] psat;
	logic second_q;
	logic [31:0] at;
	logic signed [23:0] tq;

	pcsg_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .quo(div_quo)
	);

	always_comb begin
		kn = 5'd1;
		kd = 5'd1;
		if (second_q) begin
			unique case (sh_q)
				pcsg_pkg::SH_HUYGENS: kn = 5'd3;
				pcsg_pkg::SH_HYPO: kn = 5'd2;
				pcsg_pkg::SH_EPI: begin kn = 5'd11; kd = 5'd6; end
				pcsg_pkg::SH_STAR: begin kn = 5'd2; kd = 5'd3; end
				default: begin kn = 5'd15; kd = 5'd14; end
			endcase
		end else if (sh_q == pcsg_pkg::SH_CLOUD || sh_q == pcsg_pkg::SH_ICLOUD) begin
			kd = 5'd14;
		end
		dprod = 16'(pcsg_pkg::shape_steps(sh_q)) * 16'(kd);
		div_start = 1'b0;
		div_num = '0;
		div_den = dprod;
		if (ph_q == P_PH1 || ph_q == P_PH2) begin
			div_start = 1'b1;
			div_num = {16'd0, 16'(i_q) * 16'(pcsg_pkg::shape_turns(sh_q)) * 16'(kn), 32'd0}
				+ {48'd0, 1'b0, dprod[15:1]};
		end else if (ph_q == P_T) begin
			div_start = 1'b1;
			if (sh_q == pcsg_pkg::SH_LINE) begin
				div_num = 64'({i_q, 17'd0}) + 64'(dprod[15:1]);
			end else begin
				div_num = 64'({i_q, 1'b0}) * 64'(pcsg_pkg::PI_Q29) + 64'({dprod, 11'd0});
				div_den = dprod;
			end
		end
		at = pcsg_pkg::atan_turn(5'(k_q));
		rc = 20'(($signed(x_q) + 34'sd8192) >>> 14);
		rs = 20'(($signed(y_q) + 34'sd8192) >>> 14);
		phase = 32'(div_quo);
	end

	// divisor for cycloid needs n*4096; fold by shifting quotient instead
	assign tq = (sh_q == pcsg_pkg::SH_LINE) ? 24'(div_quo) : 24'(div_quo >> 12);

	always_comb begin
		mp1 = c1_q * c1_q;
		mp2 = s1_q * s1_q;
		unique case (ph_q)
			P_M2: begin mp1 = c2_q * c1_q; mp2 = s2_q * s1_q; end
			P_M1: begin mp1 = 40'sd72090 * s1_q; mp2 = c1_q * c1_q; end
			default: ;
		endcase
		mr1 = 20'((mp1 + 40'sd32768) >>> 16);
		mr2 = 20'((mp2 + 40'sd32768) >>> 16);
	end

	always_comb begin
		vx = '0;
		vy = '0;
		unique case (sh_q)
			pcsg_pkg::SH_ASTROID: begin vx = 41'(c2_q); vy = 41'(s2_q); end
			pcsg_pkg::SH_CYCLOID: begin
				vx = (41'sd196608 - 41'sd3 * c1_q) >>> 1;
				vy = (41'sd3 * (41'(t_q) - 41'(s1_q))) >>> 1;
			end
			pcsg_pkg::SH_HUYGENS: begin
				vx = 41'sd4 * (41'sd3 * c1_q - c2_q);
				vy = 41'sd4 * (41'sd3 * s1_q - s2_q);
			end
			pcsg_pkg::SH_HYPO: begin
				vx = (41'sd3 * (41'sd2 * c1_q + c2_q)) >>> 1;
				vy = (41'sd3 * (41'sd2 * s1_q - s2_q)) >>> 1;
			end
			pcsg_pkg::SH_LINE: begin
				vx = 41'sd65536 - 41'(t_q);
				vy = 41'sd65536 - 41'(t_q);
			end
			pcsg_pkg::SH_CIRCLE: begin vx = 41'(c1_q); vy = 41'(s1_q); end
			pcsg_pkg::SH_ELLIPSE: begin vx = 41'sd2 * c1_q; vy = 41'(t_q); end
			pcsg_pkg::SH_EPI: begin
				vx = 41'sd11 * c1_q - 41'sd6 * c2_q;
				vy = 41'sd11 * s1_q - 41'sd6 * s2_q;
			end
			pcsg_pkg::SH_STAR: begin
				vx = 41'sd2 * c1_q + 41'sd5 * c2_q;
				vy = 41'sd2 * s1_q - 41'sd5 * s2_q;
			end
			pcsg_pkg::SH_ICLOUD: begin
				vx = 41'sd15 * c1_q + c2_q;
				vy = 41'sd15 * s1_q - s2_q;
			end
			default: begin
				vx = 41'sd15 * c1_q - c2_q;
				vy = 41'sd15 * s1_q - s2_q;
			end
		endcase
	end

	always_comb begin
		pacc = 64'(ax_q) * 64'($signed({1'b0, pcsg_pkg::shape_scale(sh_q)}))
			+ 64'($signed({1'b0, ((ph_q == P_PIXX) ? center_x : center_y), 16'd0}));
		pabs = pacc[63] ? -pacc : pacc;
		ptr = pacc[63] ? -(pabs >>> 16) : (pabs >>> 16);
		if (ptr > 64'((1 << (CB - 1)) - 1)) psat = CB'((1 << (CB - 1)) - 1);
		else if (ptr < -64'(1 << (CB - 1))) psat = CB'(-(1 << (CB - 1)));
		else psat = CB'(ptr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= P_IDLE;
		end else begin
			unique case (ph_q)
				P_IDLE: if (cmd.start) ph_q <= (cmd.shape == pcsg_pkg::SH_LINE) ? P_T : P_PH1;
				P_PH1: ph_q <= P_PH1W;
				P_PH1W: if (!div_busy && !div_start) ph_q <= P_C1;
				P_C1: ph_q <= P_C1W;
				P_C1W: if (k_q == ITB'(pcsg_pkg::CORDIC_ITERATIONS)) begin
					unique case (sh_q)
						pcsg_pkg::SH_ASTROID, pcsg_pkg::SH_CIRCLE: ph_q <= P_M1;
						pcsg_pkg::SH_ELLIPSE: ph_q <= P_M1;
						pcsg_pkg::SH_CYCLOID: ph_q <= P_T;
						default: ph_q <= second_q ? P_COMB : P_PH2;
					endcase
				end
				P_PH2: ph_q <= P_PH2W;
				P_PH2W: if (!div_busy) ph_q <= P_C2;
				P_C2: ph_q <= P_C1W;
				P_T: ph_q <= P_TW;
				P_TW: if (!div_busy) ph_q <= P_COMB;
				P_M1: ph_q <= (sh_q == pcsg_pkg::SH_ASTROID) ? P_M2 : P_COMB;
				P_M2: ph_q <= P_COMB;
				P_COMB: ph_q <= P_PIXX;
				P_PIXX: ph_q <= P_PIXY;
				P_PIXY: ph_q <= P_DONE;
				P_DONE: ph_q <= P_IDLE;
				default: ph_q <= P_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ph_q)
			P_IDLE: begin
				sh_q <= cmd.shape;
				i_q <= cmd.index;
				second_q <= 1'b0;
			end
			P_PH2: second_q <= 1'b1;
			P_C1, P_C2: begin
				neg_q <= phase[31] ^ phase[30];
				z_q <= 34'($signed(phase - ((phase[31] ^ phase[30]) ? 32'h80000000 : 32'd0)));
				x_q <= 34'(pcsg_pkg::CORDIC_GAIN_Q30);
				y_q <= '0;
				k_q <= '0;
			end
			P_C1W: begin
				if (k_q != ITB'(pcsg_pkg::CORDIC_ITERATIONS)) begin
					if (!z_q[33]) begin
						x_q <= x_q - (y_q >>> k_q);
						y_q <= y_q + (x_q >>> k_q);
						z_q <= z_q - 34'(at);
					end else begin
						x_q <= x_q + (y_q >>> k_q);
						y_q <= y_q - (x_q >>> k_q);
						z_q <= z_q + 34'(at);
					end
					k_q <= k_q + ITB'(1);
				end else if (!second_q) begin
					c1_q <= neg_q ? -rc : rc;
					s1_q <= neg_q ? -rs : rs;
					if (sh_q != pcsg_pkg::SH_ASTROID && sh_q != pcsg_pkg::SH_CIRCLE
						&& sh_q != pcsg_pkg::SH_ELLIPSE && sh_q != pcsg_pkg::SH_CYCLOID)
						second_q <= 1'b1;
				end else begin
					c2_q <= neg_q ? -rc : rc;
					s2_q <= neg_q ? -rs : rs;
				end
			end
			P_TW: if (!div_busy) t_q <= tq;
			P_M1: begin
				c2_q <= mr2;
				t_q <= 24'(mr1);
				s2_q <= 20'((s1_q * s1_q + 40'sd32768) >>> 16);
			end
			P_M2: begin c2_q <= mr1; s2_q <= mr2; end
			P_COMB: begin ax_q <= vx; ay_q <= vy; end
			P_PIXX: begin px <= psat; ax_q <= ay_q; end
			P_PIXY: py <= psat;
			default: ;
		endcase
	end

	assign stat.done = (ph_q == P_DONE);
endmodule

### design/pcsg_ctrl.sv
module pcsg_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic restart,
	input logic [3:0] shape,
	input pcsg_pkg::pcsg_stat_t stat,
	output pcsg_pkg::pcsg_cmd_t cmd,
	output logic out_valid,
	input logic out_stall,
	output logic last_segment,
	output logic first_q
);
	localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_OUT = 2'd2;
	logic [1:0] state_q;
	logic [9:0] step_q;
	logic active_q;
	logic [9:0] n;
	logic [9:0] nxt;
	logic valid_shape;
	logic go;

	always_comb begin
		n = pcsg_pkg::shape_steps(shape);
		valid_shape = (shape != pcsg_pkg::SH_NONE) && (shape <= pcsg_pkg::SH_ICLOUD);
		nxt = restart ? 10'd0 : ((step_q + 10'd1 > n) ? n : step_q + 10'd1);
		if (!restart && step_q >= n) nxt = n;
		go = valid_shape && (restart || active_q);
		in_stall = (state_q != S_IDLE);
		cmd.start = (state_q == S_IDLE) && in_valid && go;
		cmd.shape = shape;
		cmd.index = nxt;
		out_valid = (state_q == S_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			active_q <= 1'b0;
			last_segment <= 1'b0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					if (!valid_shape) begin
						active_q <= 1'b0;
					end else if (go) begin
						step_q <= nxt;
						last_segment <= (nxt == n);
						active_q <= (nxt != n);
						first_q <= (nxt == 10'd0);
						state_q <= S_RUN;
					end
				end
				S_RUN: if (stat.done) state_q <= S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### design/parametric_curve_segment_gen_top.sv
// Flow: the line runs only the divider for its parameter; astroid, circle and ellipse run one
// CORDIC evaluation, the cycloid one evaluation and then the divider, the other shapes two;
// each evaluation is a 48-step phase divider followed by the CORDIC iterations.
// Throughput: one request at a time; the next is taken in the cycle after the result is
// taken. A request that gives no result is taken at once, with no output.
// Reset: arst_n clears control and config state asynchronously; shape none, centers 249.
module parametric_curve_segment_gen_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic restart,
	output logic out_valid,
	input logic out_stall,
	output logic signed [pcsg_pkg::COORD_BITS-1:0] cur_x,
	output logic signed [pcsg_pkg::COORD_BITS-1:0] cur_y,
	output logic signed [pcsg_pkg::COORD_BITS-1:0] prev_x,
	output logic signed [pcsg_pkg::COORD_BITS-1:0] prev_y,
	output logic last_segment,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [11:0] cfg_data
);
	logic [3:0] shape_q;
	logic [11:0] cx_q, cy_q;
	pcsg_pkg::pcsg_cmd_t cmd;
	pcsg_pkg::pcsg_stat_t stat;
	logic first;
	logic signed [pcsg_pkg::COORD_BITS-1:0] px, py, lx_q, ly_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= pcsg_pkg::SH_NONE;
			cx_q <= 12'd249;
			cy_q <= 12'd249;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pcsg_pkg::REG_SHAPE: shape_q <= cfg_data[3:0];
				pcsg_pkg::REG_CENTER_X: cx_q <= cfg_data;
				pcsg_pkg::REG_CENTER_Y: cy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	pcsg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.restart(restart), .shape(shape_q), .stat(stat), .cmd(cmd),
		.out_valid(out_valid), .out_stall(out_stall), .last_segment(last_segment),
		.first_q(first)
	);

	pcsg_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .center_x(cx_q), .center_y(cy_q),
		.stat(stat), .px(px), .py(py)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q <= '0;
			ly_q <= '0;
		end else if (out_valid && !out_stall) begin
			lx_q <= px;
			ly_q <= py;
		end
	end

	assign cur_x = px;
	assign cur_y = py;
	assign prev_x = first ? px : lx_q;
	assign prev_y = first ? py : ly_q;
endmodule

### design/pcsg_checker.sv
module pcsg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic last_segment,
	input logic [13:0] cur_x
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cur_x)) else $error("held");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("overlap");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(last_segment)) else $error("last");
endmodule

bind parametric_curve_segment_gen_top pcsg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .last_segment(last_segment),
	.cur_x(cur_x)
);
